### hw/rtl/bsfco_pkg.sv
`default_nettype none

package bsfco_pkg;

  localparam int unsigned CW         = 16;
  localparam int unsigned LIMIT_W    = 11;
  localparam int unsigned FRAC_SHIFT = 4;
  localparam int unsigned THW        = 2 * (LIMIT_W + FRAC_SHIFT);
  localparam int unsigned SQW        = 2 * CW;
  localparam int unsigned SUMW       = SQW + 1;
  localparam int unsigned CMPW       = (SUMW > THW) ? SUMW : THW;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = LIMIT_W;
  localparam int unsigned NCORNER    = 4;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [CW:0]   key_t;
  typedef logic [CW-1:0]        mag_t;
  typedef logic [SQW-1:0]       sq_t;
  typedef logic [THW-1:0]       thr_t;
  typedef logic [CMPW-1:0]      cmp_t;
  typedef logic [1:0]           corner_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_SIDE = 1'b0,
    CFG_MAX_SIDE = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    coord_t p0_x;
    coord_t p0_y;
    coord_t p1_x;
    coord_t p1_y;
    coord_t p2_x;
    coord_t p2_y;
    coord_t p3_x;
    coord_t p3_y;
  } in_word_t;

  typedef struct packed {
    logic   keep;
    coord_t top_left_x;
    coord_t top_left_y;
    coord_t top_right_x;
    coord_t top_right_y;
    coord_t bottom_right_x;
    coord_t bottom_right_y;
    coord_t bottom_left_x;
    coord_t bottom_left_y;
    coord_t lowest_y;
  } out_word_t;

  typedef struct packed {
    corner_t tl;
    corner_t tr;
    corner_t br;
    corner_t bl;
    coord_t  lowest_y;
  } order_t;

  // x+y, exact
  function automatic key_t key_sum(coord_t x, coord_t y);
    return key_t'(x) + key_t'(y);
  endfunction

  // y-x, exact
  function automatic key_t key_dif(coord_t x, coord_t y);
    return key_t'(y) - key_t'(x);
  endfunction

endpackage

`default_nettype wire

### hw/rtl/bsfco_side.sv
`default_nettype none

module bsfco_side (
  input  bsfco_pkg::coord_t a_x_i,
  input  bsfco_pkg::coord_t a_y_i,
  input  bsfco_pkg::coord_t b_x_i,
  input  bsfco_pkg::coord_t b_y_i,
  output bsfco_pkg::sq_t    dx_sq_o,
  output bsfco_pkg::sq_t    dy_sq_o
);
  import bsfco_pkg::*;

  key_t diff_x;
  key_t diff_y;
  key_t neg_x;
  key_t neg_y;
  mag_t mag_x;
  mag_t mag_y;

  always_comb begin
    diff_x = key_t'(b_x_i) - key_t'(a_x_i);
    diff_y = key_t'(b_y_i) - key_t'(a_y_i);
    neg_x  = -diff_x;
    neg_y  = -diff_y;
    // magnitude never exceeds 2^CW-1, so the sign bit drops out
    mag_x  = diff_x[CW] ? neg_x[CW-1:0] : diff_x[CW-1:0];
    mag_y  = diff_y[CW] ? neg_y[CW-1:0] : diff_y[CW-1:0];
  end

  assign dx_sq_o = sq_t'(mag_x) * sq_t'(mag_x);
  assign dy_sq_o = sq_t'(mag_y) * sq_t'(mag_y);

endmodule

`default_nettype wire

### hw/rtl/bsfco_order.sv
`default_nettype none

module bsfco_order (
  input  bsfco_pkg::in_word_t word_i,
  output bsfco_pkg::order_t   order_o
);
  import bsfco_pkg::*;

  coord_t px [NCORNER];
  coord_t py [NCORNER];

  always_comb begin
    key_t min_sum;
    key_t max_sum;
    key_t min_dif;
    key_t max_dif;
    key_t s;
    key_t d;

    px[0] = word_i.p0_x;  py[0] = word_i.p0_y;
    px[1] = word_i.p1_x;  py[1] = word_i.p1_y;
    px[2] = word_i.p2_x;  py[2] = word_i.p2_y;
    px[3] = word_i.p3_x;  py[3] = word_i.p3_y;

    min_sum = key_sum(px[0], py[0]);
    max_sum = min_sum;
    min_dif = key_dif(px[0], py[0]);
    max_dif = min_dif;
    order_o = '{tl: '0, tr: '0, br: '0, bl: '0, lowest_y: py[0]};

    // strict compares: earliest corner keeps the role on a tie
    for (int i = 1; i < NCORNER; i++) begin
      s = key_sum(px[i], py[i]);
      d = key_dif(px[i], py[i]);
      if (s < min_sum) begin
        min_sum    = s;
        order_o.tl = corner_t'(i);
      end
      if (s > max_sum) begin
        max_sum    = s;
        order_o.br = corner_t'(i);
      end
      if (d < min_dif) begin
        min_dif    = d;
        order_o.tr = corner_t'(i);
      end
      if (d > max_dif) begin
        max_dif    = d;
        order_o.bl = corner_t'(i);
      end
      if (py[i] < order_o.lowest_y) begin
        order_o.lowest_y = py[i];
      end
    end
  end

endmodule

`default_nettype wire

### hw/rtl/box_size_filter_corner_order_unit.sv
`default_nettype none

// Text-box size filter and corner orderer. Each word is one quadrilateral of four
// signed Q12.4 corners; the result word says whether the box is kept (every closed
// side longer than min_side_limit pixels and some side longer than max_side_limit
// pixels, compared exactly on squared lengths) and gives the corners ordered
// top-left, top-right, bottom-right, bottom-left plus the smallest y. One box is
// taken every cycle unless stalled; a result passes the input register, the squarer
// register and the output register, the eight side squarers setting the middle stage.
// Limits are written through the plain write port while the unit is idle: the user
// must keep to this, the block does not enforce it. The limits are held pre-squared.
module box_size_filter_corner_order_unit (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  bsfco_pkg::in_word_t                   in_word_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output bsfco_pkg::out_word_t                  out_word_o,
  input  logic                                  cfg_we_i,
  input  logic [bsfco_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [bsfco_pkg::CFG_DATA_W-1:0]      cfg_data_i
);
  import bsfco_pkg::*;

  // limits, stored as (16*T)^2
  thr_t thr_min_q, thr_max_q;
  thr_t thr_new;

  logic      a_valid_q, b_valid_q, c_valid_q;
  logic      a_en, b_en, c_en;
  in_word_t  a_word_q;
  out_word_t b_word_q, b_word_d;
  sq_t       b_sq_q [2*NCORNER];
  sq_t       b_sq_d [2*NCORNER];
  out_word_t c_word_q, c_word_d;
  order_t    a_order;

  coord_t px [NCORNER];
  coord_t py [NCORNER];

  // stage enables: a stage moves when empty or when its successor moves
  assign c_en       = !c_valid_q || !out_stall_i;
  assign b_en       = !b_valid_q || c_en;
  assign a_en       = !a_valid_q || b_en;
  assign in_stall_o = !a_en;

  assign thr_new = thr_t'({(2*LIMIT_W)'(cfg_data_i) * (2*LIMIT_W)'(cfg_data_i),
                           {(2*FRAC_SHIFT){1'b0}}});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_min_q <= '0;
      thr_max_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MIN_SIDE: thr_min_q <= thr_new;
        CFG_MAX_SIDE: thr_max_q <= thr_new;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else begin
      if (a_en) a_valid_q <= in_valid_i;
      if (b_en) b_valid_q <= a_valid_q;
      if (c_en) c_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_en && in_valid_i) a_word_q <= in_word_i;
    if (b_en && a_valid_q) begin
      b_word_q <= b_word_d;
      b_sq_q   <= b_sq_d;
    end
    if (c_en && b_valid_q) c_word_q <= c_word_d;
  end

  // stage A -> B: side squares and corner ordering
  always_comb begin
    px[0] = a_word_q.p0_x;  py[0] = a_word_q.p0_y;
    px[1] = a_word_q.p1_x;  py[1] = a_word_q.p1_y;
    px[2] = a_word_q.p2_x;  py[2] = a_word_q.p2_y;
    px[3] = a_word_q.p3_x;  py[3] = a_word_q.p3_y;
  end

  for (genvar g = 0; g < NCORNER; g++) begin : g_side
    bsfco_side u_side (
      .a_x_i   (px[g]),
      .a_y_i   (py[g]),
      .b_x_i   (px[(g + 1) % NCORNER]),
      .b_y_i   (py[(g + 1) % NCORNER]),
      .dx_sq_o (b_sq_d[2*g]),
      .dy_sq_o (b_sq_d[2*g+1])
    );
  end

  bsfco_order u_order (
    .word_i  (a_word_q),
    .order_o (a_order)
  );

  always_comb begin
    b_word_d                = '0;
    b_word_d.top_left_x     = px[a_order.tl];
    b_word_d.top_left_y     = py[a_order.tl];
    b_word_d.top_right_x    = px[a_order.tr];
    b_word_d.top_right_y    = py[a_order.tr];
    b_word_d.bottom_right_x = px[a_order.br];
    b_word_d.bottom_right_y = py[a_order.br];
    b_word_d.bottom_left_x  = px[a_order.bl];
    b_word_d.bottom_left_y  = py[a_order.bl];
    b_word_d.lowest_y       = a_order.lowest_y;
  end

  // stage B -> C: shortest > min  <=>  every side > min;
  //               longest  > max  <=>  some side > max
  always_comb begin
    logic all_long;
    logic any_long;
    cmp_t side_len;

    all_long = 1'b1;
    any_long = 1'b0;
    for (int i = 0; i < NCORNER; i++) begin
      side_len = cmp_t'(b_sq_q[2*i]) + cmp_t'(b_sq_q[2*i+1]);
      if (!(side_len > cmp_t'(thr_min_q))) all_long = 1'b0;
      if (side_len > cmp_t'(thr_max_q))    any_long = 1'b1;
    end
    c_word_d      = b_word_q;
    c_word_d.keep = all_long && any_long;
  end

  assign out_valid_o = c_valid_q;
  assign out_word_o  = c_word_q;

`ifndef NO_ASSERTIONS
  a_tl_before_br : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> key_sum(out_word_o.top_left_x, out_word_o.top_left_y)
                    <= key_sum(out_word_o.bottom_right_x, out_word_o.bottom_right_y))
    else $error("top-left corner has larger x+y than bottom-right");

  a_tr_before_bl : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> key_dif(out_word_o.top_right_x, out_word_o.top_right_y)
                    <= key_dif(out_word_o.bottom_left_x, out_word_o.bottom_left_y))
    else $error("top-right corner has larger y-x than bottom-left");

  a_lowest_y : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_word_o.lowest_y <= out_word_o.top_left_y)
                 && (out_word_o.lowest_y <= out_word_o.bottom_right_y))
    else $error("lowest_y above a chosen corner");

  a_no_loss : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_valid_q && !c_en) |=> (b_valid_q && $stable(b_word_q)))
    else $error("middle stage lost or changed a word under stall");
`endif

endmodule

`default_nettype wire

### tb/tb_box_size_filter_corner_order_unit.sv
module tb_box_size_filter_corner_order_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import bsfco_pkg::*;

  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned DRAIN_PAD  = 8;
  localparam int unsigned HOLD_OFF   = 120;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  in_word_t              in_word_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  out_word_t             out_word_o;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  box_size_filter_corner_order_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  // shadow copy of the limit registers
  logic [CFG_DATA_W-1:0] min_side_px;
  logic [CFG_DATA_W-1:0] max_side_px;

  out_word_t   ordered_boxes_q[$];
  int unsigned errors;
  int unsigned n_boxes;
  int unsigned n_kept;
  int unsigned n_checked;
  int unsigned n_settings;
  int unsigned idle_cycles;

  bit          tx_calm;
  bit          rx_calm;
  int unsigned rx_hold;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned draw_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic in_word_t box(int ax, int ay, int bx, int by,
                                   int cx, int cy, int dx, int dy);
    in_word_t w;
    w.p0_x = coord_t'(ax);
    w.p0_y = coord_t'(ay);
    w.p1_x = coord_t'(bx);
    w.p1_y = coord_t'(by);
    w.p2_x = coord_t'(cx);
    w.p2_y = coord_t'(cy);
    w.p3_x = coord_t'(dx);
    w.p3_y = coord_t'(dy);
    return w;
  endfunction

  function automatic out_word_t order_and_filter(in_word_t w);
    int        xs[4];
    int        ys[4];
    longint    side_sq;
    longint    shortest;
    longint    longest;
    longint    thr_min;
    longint    thr_max;
    int        tl, tr, br, bl, low, k, j;
    out_word_t r;
    xs[0] = w.p0_x;  ys[0] = w.p0_y;
    xs[1] = w.p1_x;  ys[1] = w.p1_y;
    xs[2] = w.p2_x;  ys[2] = w.p2_y;
    xs[3] = w.p3_x;  ys[3] = w.p3_y;
    shortest = 0;
    longest  = 0;
    for (k = 0; k < 4; k++) begin
      j = (k + 1) % 4;
      side_sq = longint'(xs[j] - xs[k]) * longint'(xs[j] - xs[k])
              + longint'(ys[j] - ys[k]) * longint'(ys[j] - ys[k]);
      if (k == 0 || side_sq < shortest) shortest = side_sq;
      if (k == 0 || side_sq > longest) longest = side_sq;
    end
    thr_min = longint'(min_side_px) * 16;
    thr_min = thr_min * thr_min;
    thr_max = longint'(max_side_px) * 16;
    thr_max = thr_max * thr_max;
    // strict compares: the earliest corner keeps a tied role
    tl = 0; tr = 0; br = 0; bl = 0;
    low = ys[0];
    for (k = 1; k < 4; k++) begin
      if (xs[k] + ys[k] < xs[tl] + ys[tl]) tl = k;
      if (xs[k] + ys[k] > xs[br] + ys[br]) br = k;
      if (ys[k] - xs[k] < ys[tr] - xs[tr]) tr = k;
      if (ys[k] - xs[k] > ys[bl] - xs[bl]) bl = k;
      if (ys[k] < low) low = ys[k];
    end
    r.keep           = (thr_min < shortest) && (thr_max < longest);
    r.top_left_x     = coord_t'(xs[tl]);
    r.top_left_y     = coord_t'(ys[tl]);
    r.top_right_x    = coord_t'(xs[tr]);
    r.top_right_y    = coord_t'(ys[tr]);
    r.bottom_right_x = coord_t'(xs[br]);
    r.bottom_right_y = coord_t'(ys[br]);
    r.bottom_left_x  = coord_t'(xs[bl]);
    r.bottom_left_y  = coord_t'(ys[bl]);
    r.lowest_y       = coord_t'(low);
    return r;
  endfunction

  function automatic in_word_t random_box();
    int          bx[4];
    int          by[4];
    int          px[4];
    int          py[4];
    int          w, h, ox, oy, s, d, k, side;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      return in_word_t'({$urandom(), $urandom(), $urandom(), $urandom()});
    end
    if (r < 20) begin
      // tiny grid: ties in both keys are common
      for (k = 0; k < 4; k++) begin
        px[k] = int'($urandom_range(0, 6)) - 3;
        py[k] = int'($urandom_range(0, 6)) - 3;
      end
      return box(px[0], py[0], px[1], py[1], px[2], py[2], px[3], py[3]);
    end
    if (r < 25) begin
      // at most two distinct points
      ox = int'($urandom_range(0, 65535)) - 32768;
      oy = int'($urandom_range(0, 65535)) - 32768;
      w  = int'($urandom_range(0, 65535)) - 32768;
      h  = int'($urandom_range(0, 65535)) - 32768;
      for (k = 0; k < 4; k++) begin
        s = $urandom_range(0, 1);
        px[k] = s ? ox : w;
        py[k] = s ? oy : h;
      end
      return box(px[0], py[0], px[1], py[1], px[2], py[2], px[3], py[3]);
    end
    if (r < 40) begin
      // square right at the shortest-side limit
      side = int'(min_side_px) * 16 + int'($urandom_range(0, 2)) - 1;
      if (side < 0) side = 0;
      w = side;
      h = side;
    end else if (r < 50) begin
      // long side right at the longest-side limit
      w = int'(max_side_px) * 16 + int'($urandom_range(0, 2)) - 1;
      if (w < 0) w = 0;
      h = $urandom_range(0, w);
    end else begin
      w = $urandom_range(0, 3200);
      h = $urandom_range(0, 3200);
    end
    ox = int'($urandom_range(0, 65535 - w)) - 32768;
    oy = int'($urandom_range(0, 65535 - h)) - 32768;
    bx[0] = ox;      by[0] = oy;
    bx[1] = ox + w;  by[1] = oy;
    bx[2] = ox + w;  by[2] = oy + h;
    bx[3] = ox;      by[3] = oy + h;
    s = $urandom_range(0, 3);
    d = $urandom_range(0, 1) ? 1 : 3;
    for (k = 0; k < 4; k++) begin
      px[k] = bx[(s + d * k) % 4];
      py[k] = by[(s + d * k) % 4];
      // skew the plain rectangles a little, staying in range
      if (r >= 50) begin
        px[k] = px[k] + int'($urandom_range(0, 16)) - 8;
        py[k] = py[k] + int'($urandom_range(0, 16)) - 8;
        if (px[k] > 32767) px[k] = 32767;
        if (px[k] < -32768) px[k] = -32768;
        if (py[k] > 32767) py[k] = 32767;
        if (py[k] < -32768) py[k] = -32768;
      end
    end
    return box(px[0], py[0], px[1], py[1], px[2], py[2], px[3], py[3]);
  endfunction

  // valid stays high after acceptance; the next send or a drain sets it
  task automatic send_box(input in_word_t w);
    int unsigned gap;
    out_word_t   res;
    gap = tx_calm ? 0 : draw_gap();
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
    res = order_and_filter(w);
    ordered_boxes_q = {ordered_boxes_q, res};
    n_boxes++;
    if (res.keep) n_kept++;
  endtask

  task automatic wait_drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (ordered_boxes_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_PAD) @(posedge clk_i);
  endtask

  task automatic set_limits(input logic [CFG_DATA_W-1:0] min_px,
                            input logic [CFG_DATA_W-1:0] max_px);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_MIN_SIDE;
    cfg_data_i <= min_px;
    @(negedge clk_i);
    cfg_idx_i  <= CFG_MAX_SIDE;
    cfg_data_i <= max_px;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    min_side_px = min_px;
    max_side_px = max_px;
    n_settings++;
  endtask

  task automatic test_directed();
    set_limits(11'd0, 11'd0);
    send_box(box(0, 0, 0, 0, 0, 0, 0, 0));
    send_box(box(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
    send_box(box(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768));
    send_box(box(-32768, -32768, -32768, 32767, 32767, 32767, 32767, -32768));
    // diagonal sides at full range need the carry bit
    send_box(box(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
    send_box(box(100, 200, 900, 200, 900, 700, 100, 700));
    send_box(box(900, 700, 100, 700, 100, 200, 900, 200));
    // diamond: both keys tie pairwise
    send_box(box(0, -16, 16, 0, 0, 16, -16, 0));
    // one zero-length side drops the box even at limit 0
    send_box(box(0, 0, 0, 0, 1600, 0, 1600, 1600));
    wait_drain();
    set_limits(11'd10, 11'd10);
    send_box(box(0, 0, 160, 0, 160, 160, 0, 160));
    send_box(box(0, 0, 161, 0, 161, 161, 0, 161));
    wait_drain();
    set_limits(11'd2047, 11'd2047);
    send_box(box(-16384, -16384, 16368, -16384, 16368, 16368, -16384, 16368));
    send_box(box(-16384, -16384, 16369, -16384, 16369, 16369, -16384, 16369));
    wait_drain();
    set_limits(11'd0, 11'd2047);
    send_box(box(-16384, 0, 16369, 0, 16369, 16, -16384, 16));
    send_box(box(-16384, 0, 16368, 0, 16368, 16, -16384, 16));
    wait_drain();
    set_limits(11'd2047, 11'd0);
    send_box(box(-20000, -20000, 20000, -20000, 20000, 20000, -20000, 20000));
    send_box(box(-20000, 0, 20000, 0, 20000, 100, -20000, 100));
    wait_drain();
  endtask

  task automatic test_random_boxes();
    int ph;
    for (ph = 0; ph < 5; ph++) begin
      case (ph)
        0: set_limits(11'd0, 11'd0);
        1: set_limits(11'($urandom_range(0, 160)), 11'($urandom_range(0, 320)));
        2: set_limits(11'($urandom_range(0, 160)), 11'($urandom_range(0, 320)));
        3: set_limits(11'($urandom_range(0, 2047)), 11'($urandom_range(0, 2047)));
        default: set_limits(11'd2047, 11'd2047);
      endcase
      repeat (110) send_box(random_box());
      wait_drain();
    end
  endtask

  task automatic test_back_to_back();
    set_limits(11'($urandom_range(0, 100)), 11'($urandom_range(0, 200)));
    tx_calm = 1'b1;
    rx_calm = 1'b1;
    repeat (80) send_box(random_box());
    tx_calm = 1'b0;
    rx_calm = 1'b0;
    wait_drain();
  endtask

  // receiver blocks for a long stretch while boxes keep coming
  task automatic test_output_hold_off();
    set_limits(11'($urandom_range(0, 100)), 11'($urandom_range(0, 200)));
    tx_calm = 1'b1;
    rx_hold = HOLD_OFF;
    repeat (60) send_box(random_box());
    tx_calm = 1'b0;
    wait_drain();
  endtask

  initial begin : receiver
    int unsigned stall_run;
    int unsigned hold;
    stall_run = 0;
    forever begin
      @(negedge clk_i);
      if (rx_hold != 0) begin
        hold    = rx_hold;
        rx_hold = 0;
        out_stall_i <= 1'b1;
        repeat (hold - 1) @(negedge clk_i);
      end else if (stall_run != 0) begin
        out_stall_i <= 1'b1;
        stall_run--;
      end else begin
        out_stall_i <= 1'b0;
        if (!rx_calm) stall_run = draw_gap();
      end
    end
  end

  function automatic void check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endfunction

  always @(posedge clk_i) begin : result_check
    out_word_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (ordered_boxes_q.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
      end else begin
        e = ordered_boxes_q.pop_front();
        check_field("keep", int'(e.keep), int'(out_word_o.keep));
        check_field("top_left_x", int'(e.top_left_x), int'(out_word_o.top_left_x));
        check_field("top_left_y", int'(e.top_left_y), int'(out_word_o.top_left_y));
        check_field("top_right_x", int'(e.top_right_x), int'(out_word_o.top_right_x));
        check_field("top_right_y", int'(e.top_right_y), int'(out_word_o.top_right_y));
        check_field("bottom_right_x", int'(e.bottom_right_x),
                    int'(out_word_o.bottom_right_x));
        check_field("bottom_right_y", int'(e.bottom_right_y),
                    int'(out_word_o.bottom_right_y));
        check_field("bottom_left_x", int'(e.bottom_left_x),
                    int'(out_word_o.bottom_left_x));
        check_field("bottom_left_y", int'(e.bottom_left_y),
                    int'(out_word_o.bottom_left_y));
        check_field("lowest_y", int'(e.lowest_y), int'(out_word_o.lowest_y));
        n_checked++;
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("Timeout: no word moved for %0d cycles", IDLE_LIMIT);
          $display("Testbench completed WITH ERRORS");
          $finish;
        end
      end
    end
  end

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_word_i   = '0;
    out_stall_i = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = '0;
    cfg_data_i  = '0;
    min_side_px = '0;
    max_side_px = '0;
    errors      = 0;
    n_boxes     = 0;
    n_kept      = 0;
    n_checked   = 0;
    n_settings  = 0;
    idle_cycles = 0;
    tx_calm     = 1'b0;
    rx_calm     = 1'b0;
    rx_hold     = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_random_boxes();
    test_back_to_back();
    test_output_hold_off();

    $display("Sent %0d boxes (%0d kept) over %0d limit settings; %0d results checked.",
             n_boxes, n_kept, n_settings, n_checked);
    $display("Covered degenerate, tied and full-range corners, limit edges and back-pressure.");
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
